// ===== sv/ccp_pkg.sv =====
// Package for the capsule coverage pixel unit.
// Shared widths, stage counts and the sideband record; no dependencies.
`default_nettype none

package ccp_pkg;

  // Pixels per line; a column at or beyond it is not drawn
  localparam int LINE_PIXELS = 256;
  localparam int LINE_W      = 11;

  // Differences of coordinates, products and sums
  localparam int DIFF_W = 17;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;

  // Magnitudes after the case split (all below 2^29)
  localparam int MAG_W = 30;

  // Divider: 58-bit numerator scaled by 2^16, quotient below 2^45
  localparam int NUM_W      = 58;
  localparam int QUO_W      = 45;
  localparam int DIV_STAGES = QUO_W;

  // Square root of the 45-bit squared distance, padded to 46 bits
  localparam int RAD_IN_W    = 2 * ((QUO_W + 1) / 2);
  localparam int SQRT_STAGES = RAD_IN_W / 2;
  localparam int SQ_REM_W    = SQRT_STAGES + 3;

  // Data travelling beside the arithmetic
  typedef struct packed {
    logic       active;
    logic [9:0] rad;
    logic [7:0] prev;
  } side_t;

endpackage

`default_nettype wire

// ===== sv/ccp_geom.sv =====
// Front stages: differences, products, sums, case split and the divider operands.
// Depends on ccp_pkg.
`default_nettype none

module ccp_geom
  import ccp_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [7:0]               pixel_x_i,
  input  wire logic [7:0]               pixel_y_i,
  input  wire logic signed [13:0]       seg_start_x_i,
  input  wire logic signed [13:0]       seg_start_y_i,
  input  wire logic signed [13:0]       seg_end_x_i,
  input  wire logic signed [13:0]       seg_end_y_i,
  input  wire logic [9:0]               half_width_i,
  input  wire logic [7:0]               prev_coverage_i,
  output logic                          valid_o,
  output logic [NUM_W-1:0]              numer_o,
  output logic [MAG_W-1:0]              denom_o,
  output side_t                         side_o
);

  logic [4:0] v_q;

  // Stage 1: differences
  logic signed [DIFF_W-1:0] px, py;
  logic signed [DIFF_W-1:0] dx_q, dy_q, ex_q, ey_q, fx_q, fy_q;
  side_t                    s1_q;
  side_t                    s1_d;

  assign px = DIFF_W'($signed({1'b0, pixel_x_i, 4'b0000}));
  assign py = DIFF_W'($signed({1'b0, pixel_y_i, 4'b0000}));

  always_comb begin
    s1_d.active = ({3'b000, pixel_x_i} < LINE_W'(LINE_PIXELS));
    s1_d.rad    = half_width_i;
    s1_d.prev   = prev_coverage_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= px - DIFF_W'(seg_start_x_i);
      dy_q <= py - DIFF_W'(seg_start_y_i);
      ex_q <= DIFF_W'(seg_end_x_i) - DIFF_W'(seg_start_x_i);
      ey_q <= DIFF_W'(seg_end_y_i) - DIFF_W'(seg_start_y_i);
      fx_q <= px - DIFF_W'(seg_end_x_i);
      fy_q <= py - DIFF_W'(seg_end_y_i);
      s1_q <= s1_d;
    end
  end

  // Stage 2: products
  logic signed [PROD_W-1:0] exex_q, eyey_q, dxex_q, dyey_q, dxey_q, dyex_q;
  logic signed [PROD_W-1:0] dxdx_q, dydy_q, fxfx_q, fyfy_q;
  side_t                    s2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exex_q <= ex_q * ex_q;
      eyey_q <= ey_q * ey_q;
      dxex_q <= dx_q * ex_q;
      dyey_q <= dy_q * ey_q;
      dxey_q <= dx_q * ey_q;
      dyex_q <= dy_q * ex_q;
      dxdx_q <= dx_q * dx_q;
      dydy_q <= dy_q * dy_q;
      fxfx_q <= fx_q * fx_q;
      fyfy_q <= fy_q * fy_q;
      s2_q   <= s1_q;
    end
  end

  // Stage 3: squared length, dot and cross products, endpoint distances
  logic signed [SUM_W-1:0] ee_q, dot_q, cr_q, dd_q, ff_q;
  side_t                   s3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ee_q  <= SUM_W'(exex_q) + SUM_W'(eyey_q);
      dot_q <= SUM_W'(dxex_q) + SUM_W'(dyey_q);
      cr_q  <= SUM_W'(dxey_q) - SUM_W'(dyex_q);
      dd_q  <= SUM_W'(dxdx_q) + SUM_W'(dydy_q);
      ff_q  <= SUM_W'(fxfx_q) + SUM_W'(fyfy_q);
      s3_q  <= s2_q;
    end
  end

  // Stage 4: which part of the capsule is nearest
  logic                    on_seg, past_end;
  logic signed [SUM_W-1:0] cr_abs;
  logic                    mid_q;
  logic [MAG_W-1:0]        num_q, den_q, endv_q;
  side_t                   s4_q;

  assign on_seg   = (ee_q != '0) && (dot_q > 0) && (dot_q < ee_q);
  assign past_end = (ee_q != '0) && (dot_q > 0) && !(dot_q < ee_q);
  assign cr_abs   = cr_q[SUM_W-1] ? -cr_q : cr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q  <= on_seg;
      num_q  <= cr_abs[MAG_W-1:0];
      den_q  <= ee_q[MAG_W-1:0];
      endv_q <= past_end ? ff_q[MAG_W-1:0] : dd_q[MAG_W-1:0];
      s4_q   <= s3_q;
    end
  end

  // Stage 5: squared cross product over the squared length, or the
  // squared endpoint distance over one
  logic [2*MAG_W-1:0] sq;

  assign sq = num_q * num_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numer_o <= mid_q ? sq[NUM_W-1:0] : NUM_W'(endv_q);
      denom_o <= mid_q ? den_q : MAG_W'(1);
      side_o  <= s4_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  assign valid_o = v_q[4];

endmodule

`default_nettype wire

// ===== sv/ccp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(numer * 2^16 / denom); depends on ccp_pkg.
`default_nettype none

module ccp_div
  import ccp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  numer_i,
  input  wire logic [MAG_W-1:0]  denom_i,
  input  wire side_t             side_i,
  output logic                   valid_o,
  output logic [QUO_W-1:0]       quo_o,
  output side_t                  side_o
);

  localparam int LOW_N = NUM_W - (NUM_W + 16 - QUO_W);

  logic [MAG_W-1:0] rem_q  [DIV_STAGES];
  logic [QUO_W-1:0] bits_q [DIV_STAGES];
  logic [MAG_W-1:0] den_q  [DIV_STAGES];
  side_t            side_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] v_q;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [MAG_W-1:0] rem_in, den_in;
    logic [QUO_W-1:0] bits_in;
    side_t            side_in;
    logic [MAG_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      // top dividend bits start the remainder, the rest shift in
      assign rem_in  = MAG_W'(numer_i[NUM_W-1:LOW_N]);
      assign bits_in = {numer_i[LOW_N-1:0], 16'h0000};
      assign den_in  = denom_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign bits_in = bits_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in one dividend bit, subtract where it fits
    assign trial = {rem_in, bits_in[QUO_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? MAG_W'(trial - {1'b0, den_in}) : trial[MAG_W-1:0];
        bits_q[k] <= {bits_in[QUO_W-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quo_o   = bits_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/ccp_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Gives floor(sqrt(n)); depends on ccp_pkg.
`default_nettype none

module ccp_sqrt
  import ccp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [QUO_W-1:0]        n_i,
  input  wire side_t                   side_i,
  output logic                         valid_o,
  output logic [SQRT_STAGES-1:0]       root_o,
  output side_t                        side_o
);

  logic [SQ_REM_W-1:0]    rem_q  [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] root_q [SQRT_STAGES];
  logic [RAD_IN_W-1:0]    rest_q [SQRT_STAGES];
  side_t                  side_q [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] v_q;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [SQ_REM_W-1:0]    rem_in;
    logic [SQRT_STAGES-1:0] root_in;
    logic [RAD_IN_W-1:0]    rest_in;
    side_t                  side_in;
    logic [SQ_REM_W+1:0]    acc, trial;
    logic                   ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = RAD_IN_W'(n_i);
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rest_in = rest_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next bit pair, try root*4+1
    assign acc   = {rem_in, rest_in[RAD_IN_W-1:RAD_IN_W-2]};
    assign trial = (SQ_REM_W + 2)'({root_in, 2'b01});
    assign ge    = (acc >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? SQ_REM_W'(acc - trial) : acc[SQ_REM_W-1:0];
        root_q[k] <= {root_in[SQRT_STAGES-2:0], ge};
        rest_q[k] <= {rest_in[RAD_IN_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[SQRT_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = v_q[SQRT_STAGES-1];
  assign root_o  = root_q[SQRT_STAGES-1];
  assign side_o  = side_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/ccp_cov.sv =====
// Last stage: distance to coverage ramp and merge with the earlier coverage.
// Depends on ccp_pkg.
`default_nettype none

module ccp_cov
  import ccp_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [SQRT_STAGES-1:0]  dist_i,
  input  wire side_t                   side_i,
  output logic                         valid_o,
  output logic [7:0]                   shape_coverage_o,
  output logic [7:0]                   merged_coverage_o
);

  logic signed [24:0] c;
  logic [19:0]        ramp;
  logic [7:0]         cov;
  logic               v_q;

  // c = half a pixel + radius - distance, in 1/4096 px
  assign c = 25'sd2048 + $signed({7'b0, side_i.rad, 8'h00})
           - $signed(25'({2'b00, dist_i}));

  assign ramp = {c[11:0], 8'h00} - {8'h00, c[11:0]} + 20'd2048;

  always_comb begin
    priority if (!side_i.active || c <= 0) begin
      cov = 8'd0;
    end else if (c >= 25'sd4096) begin
      cov = 8'd255;
    end else begin
      cov = ramp[19:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      shape_coverage_o  <= cov;
      merged_coverage_o <= (cov > side_i.prev) ? cov : side_i.prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  assign valid_o = v_q;

endmodule

`default_nettype wire

// ===== sv/capsule_coverage_pixel_unit.sv =====
// Top level of the capsule coverage pixel unit: pipeline and output skid stage.
// Depends on ccp_pkg, ccp_geom, ccp_div, ccp_sqrt and ccp_cov.
//
//  channel  direction  payload
//  s_axis   in         pixel, segment endpoints, half width, earlier coverage
//  m_axis   out        shape coverage, merged coverage
//
// One pixel per clock while the output is not stalled; 75 register stages: 5 front
// stages, 45 divider stages, 23 square root stages, the ramp and the output
// register.
// Reset clears only valid bits; payload is not reset.
// A stalled output holds its item and one more lands in the skid register;
// the pipeline then freezes as a whole until the skid register drains.
`default_nettype none

module capsule_coverage_pixel_unit
  import ccp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] pixel_x, [15:8] pixel_y, [29:16] seg_start_x, [43:30] seg_start_y,
  // [57:44] seg_end_x, [71:58] seg_end_y, [81:72] half_width,
  // [89:82] prev_coverage, [95:90] zero
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] shape_coverage, [15:8] merged_coverage
  output logic [15:0]      m_axis_tdata
);

  logic             adv;
  logic             g_v, d_v, r_v, c_v;
  logic [NUM_W-1:0] numer;
  logic [MAG_W-1:0] denom;
  side_t            g_side, d_side, r_side;
  logic [QUO_W-1:0] quo;
  logic [SQRT_STAGES-1:0] root;
  logic [7:0]       shape, merged;

  logic             out_v_q, skid_v_q;
  logic [15:0]      out_q, skid_q;

  // Pipeline moves whenever the skid register is free
  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;

  ccp_geom u_geom (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .valid_i         (s_axis_tvalid),
    .pixel_x_i       (s_axis_tdata[7:0]),
    .pixel_y_i       (s_axis_tdata[15:8]),
    .seg_start_x_i   (s_axis_tdata[29:16]),
    .seg_start_y_i   (s_axis_tdata[43:30]),
    .seg_end_x_i     (s_axis_tdata[57:44]),
    .seg_end_y_i     (s_axis_tdata[71:58]),
    .half_width_i    (s_axis_tdata[81:72]),
    .prev_coverage_i (s_axis_tdata[89:82]),
    .valid_o         (g_v),
    .numer_o         (numer),
    .denom_o         (denom),
    .side_o          (g_side)
  );

  ccp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g_v),
    .numer_i (numer),
    .denom_i (denom),
    .side_i  (g_side),
    .valid_o (d_v),
    .quo_o   (quo),
    .side_o  (d_side)
  );

  ccp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_v),
    .n_i     (quo),
    .side_i  (d_side),
    .valid_o (r_v),
    .root_o  (root),
    .side_o  (r_side)
  );

  ccp_cov u_cov (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (adv),
    .valid_i           (r_v),
    .dist_i            (root),
    .side_i            (r_side),
    .valid_o           (c_v),
    .shape_coverage_o  (shape),
    .merged_coverage_o (merged)
  );

  // Output register and skid register, control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q  <= skid_v_q || c_v;
      skid_v_q <= 1'b0;
    end else if (c_v && adv) begin
      skid_v_q <= 1'b1;
    end
  end

  // Output register and skid register, payload
  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : {merged, shape};
    end else if (adv) begin
      skid_q <= {merged, shape};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
